// ===== hdl/bitmap_run_length_delta_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the run-length delta decoder
// Shared property templates, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RUN_LENGTH_DELTA_DECODER_MACROS_SVH
`define BITMAP_RUN_LENGTH_DELTA_DECODER_MACROS_SVH

// same-cycle implication
`define BRLD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BRLD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/brld_pkg.sv =====
// ----------------------------------------------------------------------------
// brld_pkg
// Constants, codes and types of the run-length delta decoder.
// ----------------------------------------------------------------------------
package brld_pkg;

	localparam int MAX_PIXELS  = 262144;
	localparam int WORD_BITS   = 32;
	localparam int STORE_WORDS = (MAX_PIXELS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W      = $clog2(STORE_WORDS);
	localparam int OFF_W       = $clog2(WORD_BITS);
	localparam int PIX_W       = 19;
	localparam int LEN_W       = 20;
	localparam int RESET_PIXELS = 262144;

	// opcodes
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_EOF  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// run kinds
	localparam logic [1:0] KIND_SKIP   = 2'd0;
	localparam logic [1:0] KIND_WHITE  = 2'd1;
	localparam logic [1:0] KIND_BLACK  = 2'd2;
	localparam logic [1:0] KIND_INVERT = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_PAST_END = 2'd1;
	localparam logic [1:0] STAT_TRUNC    = 2'd2;
	localparam logic [1:0] STAT_TOO_LONG = 2'd3;

	// extension byte counter
	localparam logic [1:0] EXT_NONE = 2'd0;
	localparam logic [1:0] EXT_ONE  = 2'd1;
	localparam logic [1:0] EXT_TWO  = 2'd2;

	typedef struct packed {
		logic                 valid;
		logic [ADDR_W-1:0]    addr;
		logic [WORD_BITS-1:0] mask;
		logic [1:0]           kind;
	} wr_stage_t;

endpackage

// ===== hdl/bitmap_run_length_delta_decoder.sv =====
// ----------------------------------------------------------------------------
// bitmap_run_length_delta_decoder
// Applies a run-length delta stream in place over a packed 1-bit frame store.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tuser: opcode; tdata: data_byte, read_address
//  m_*       out  m_tvalid/m_tready   tdata: status, read_word, pixel_position
//  cfg_*     in   cfg_wr_en           cfg_wr_data: frame_pixels
//
//  An item passes through accept, execute, drain and respond; a run that paints
//  or inverts adds a walk over every store word it touches (one read-modify-write
//  per cycle through the single store port pair).
//  After reset a clearing pass zeroes all STORE_WORDS (8192) store words with
//  s_tready low. The result sits in an output register, so the next beat
//  is taken while m_tvalid waits; a full output register stalls the respond step.
module bitmap_run_length_delta_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [23:0]                 s_tdata,    // data_byte[7:0], read_address[20:8]
	input  logic [1:0]                  s_tuser,    // opcode[1:0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [55:0]                 m_tdata,    // status[1:0], read_word[33:2],
	                                                // pixel_position[52:34]
	input  logic                        cfg_wr_en,
	input  logic [brld_pkg::PIX_W-1:0]  cfg_wr_data
);
	import brld_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_EXEC, ST_RUN, ST_DRAIN, ST_RESP
	} state_t;

	localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

	state_t                state_q;
	logic [ADDR_W-1:0]     clr_addr_q;
	logic [1:0]            op_q;
	logic [7:0]            byte_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [PIX_W-1:0]      frame_pixels_q;
	logic [PIX_W-1:0]      pos_q;
	logic [1:0]            ptype_q;
	logic [LEN_W-1:0]      plen_q;
	logic [1:0]            ext_q;
	logic [1:0]            err_q;
	logic [ADDR_W-1:0]     word_q;
	logic [ADDR_W-1:0]     last_word_q;
	logic                  first_q;
	logic [OFF_W-1:0]      first_off_q;
	logic [OFF_W:0]        end_off_q;
	logic [1:0]            kind_q;
	wr_stage_t             wr_s1;
	logic [WORD_BITS-1:0]  rd_data_q;
	logic [1:0]            res_status_q;
	logic [WORD_BITS-1:0]  res_word_q;
	logic                  m_tvalid_q;
	logic [55:0]           m_tdata_q;

	logic [WORD_BITS-1:0]  mem [STORE_WORDS];

	// byte decode
	logic [PIX_W-1:0]      limit;
	logic [7:0]            add7;
	logic [LEN_W-1:0]      ext_add;
	logic [LEN_W-1:0]      ext_sum;
	logic [1:0]            n_ptype;
	logic [LEN_W-1:0]      n_plen;
	logic [1:0]            n_ext;
	logic [1:0]            n_err;
	logic                  run_req;
	logic [1:0]            run_kind;
	logic [LEN_W-1:0]      run_len;
	logic [LEN_W:0]        run_end;
	logic [LEN_W:0]        run_end_m1;
	logic                  run_over;

	// run stepping and memory ports
	logic [OFF_W-1:0]      off_a;
	logic [OFF_W:0]        off_b;
	logic [WORD_BITS-1:0]  step_mask;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr;
	logic [WORD_BITS-1:0]  mem_wdata;
	logic                  addr_in_range;
	logic [1:0]            eof_status;

	assign limit = ({1'b0, frame_pixels_q} > (PIX_W+1)'(MAX_PIXELS))
		? PIX_W'(MAX_PIXELS) : frame_pixels_q;

	always_comb begin
		add7     = {1'b0, byte_q[6:0]} + 8'd1;
		ext_add  = (ext_q == EXT_ONE) ? (LEN_W'(add7) << 5) : (LEN_W'(add7) << 12);
		ext_sum  = plen_q + ext_add;
		n_ptype  = ptype_q;
		n_plen   = plen_q;
		n_ext    = ext_q;
		n_err    = err_q;
		run_req  = 1'b0;
		run_kind = KIND_SKIP;
		run_len  = '0;
		if (err_q == STAT_OK) begin
			if (ext_q == EXT_NONE) begin
				if (byte_q[5]) begin
					n_ptype = byte_q[7:6];
					n_plen  = LEN_W'(byte_q[4:0]);
					n_ext   = EXT_ONE;
				end else begin
					run_req  = 1'b1;
					run_kind = byte_q[7:6];
					run_len  = LEN_W'(byte_q[4:0]) + LEN_W'(1);
				end
			end else if (ext_q == EXT_ONE && byte_q[7]) begin
				n_plen = ext_sum;
				n_ext  = EXT_TWO;
			end else if (byte_q[7]) begin
				// continuation past the second extension byte
				n_err   = STAT_TOO_LONG;
				n_ext   = EXT_NONE;
				n_plen  = '0;
				n_ptype = KIND_SKIP;
			end else begin
				n_ext    = EXT_NONE;
				n_plen   = '0;
				n_ptype  = KIND_SKIP;
				run_req  = 1'b1;
				run_kind = ptype_q;
				run_len  = ext_sum + LEN_W'(1);
			end
		end
		run_end    = (LEN_W+1)'(pos_q) + (LEN_W+1)'(run_len);
		run_end_m1 = run_end - (LEN_W+1)'(1);
		run_over   = run_end > (LEN_W+1)'(limit);
		if (run_req && run_over) begin
			n_err = STAT_PAST_END;
		end
	end

	assign eof_status = (err_q == STAT_OK && ext_q != EXT_NONE) ? STAT_TRUNC : err_q;
	assign addr_in_range = (ADDR_W+1)'(addr_q) < (ADDR_W+1)'(STORE_WORDS);

	// mask of the word under the run: pixels off_a .. off_b-1, MSB first
	assign off_a     = first_q ? first_off_q : '0;
	assign off_b     = (word_q == last_word_q) ? end_off_q : (OFF_W+1)'(WORD_BITS);
	assign step_mask = (ALL_ONES >> off_a) & ~(ALL_ONES >> off_b);

	assign rd_addr   = (state_q == ST_RUN) ? word_q : addr_q;

	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = wr_s1.valid;
			mem_waddr = wr_s1.addr;
			case (wr_s1.kind)
				KIND_WHITE: mem_wdata = rd_data_q | wr_s1.mask;
				KIND_BLACK: mem_wdata = rd_data_q & ~wr_s1.mask;
				default:    mem_wdata = rd_data_q ^ wr_s1.mask;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_addr_q     <= '0;
			frame_pixels_q <= PIX_W'(RESET_PIXELS);
			pos_q          <= '0;
			ptype_q        <= KIND_SKIP;
			plen_q         <= '0;
			ext_q          <= EXT_NONE;
			err_q          <= STAT_OK;
			wr_s1.valid    <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				frame_pixels_q <= cfg_wr_data;
			end
			if (state_q == ST_RESP && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(STORE_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						byte_q  <= s_tdata[7:0];
						addr_q  <= s_tdata[8 +: ADDR_W];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_word_q <= '0;
					// only a paint or invert run walks the store
					state_q    <= (op_q == OP_BYTE && run_req && !run_over
						&& run_kind != KIND_SKIP) ? ST_RUN : ST_DRAIN;
					unique case (op_q)
						OP_BYTE: begin
							ptype_q      <= n_ptype;
							plen_q       <= n_plen;
							ext_q        <= n_ext;
							err_q        <= n_err;
							res_status_q <= n_err;
							if (run_req && !run_over) begin
								pos_q       <= PIX_W'(run_end);
								kind_q      <= run_kind;
								word_q      <= pos_q[OFF_W +: ADDR_W];
								last_word_q <= run_end_m1[OFF_W +: ADDR_W];
								first_q     <= 1'b1;
								first_off_q <= pos_q[OFF_W-1:0];
								end_off_q   <= (OFF_W+1)'(run_end_m1[OFF_W-1:0])
									+ (OFF_W+1)'(1);
							end
						end
						OP_EOF: begin
							res_status_q <= eof_status;
							pos_q        <= '0;
							ptype_q      <= KIND_SKIP;
							plen_q       <= '0;
							ext_q        <= EXT_NONE;
							err_q        <= STAT_OK;
						end
						default: begin
							res_status_q <= err_q;
						end
					endcase
				end
				ST_RUN: begin
					wr_s1.valid <= 1'b1;
					wr_s1.addr  <= word_q;
					wr_s1.mask  <= step_mask;
					wr_s1.kind  <= kind_q;
					first_q     <= 1'b0;
					word_q      <= word_q + ADDR_W'(1);
					if (word_q == last_word_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last write of a run lands at this edge
					wr_s1.valid <= 1'b0;
					if (op_q == OP_READ && addr_in_range) begin
						res_word_q <= rd_data_q;
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {3'b000, pos_q, res_word_q, res_status_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`include "bitmap_run_length_delta_decoder_macros.svh"

	`BRLD_ASSERT_NXT(a_wr_from_run, !wr_s1.valid && state_q != ST_RUN, !wr_s1.valid, "stray write")
	`BRLD_ASSERT_IMP(a_pos_bound, 1'b1, pos_q <= PIX_W'(MAX_PIXELS), "position past store")
	`BRLD_ASSERT_IMP(a_run_words, state_q == ST_RUN, word_q <= last_word_q, "run past last word")
	`BRLD_ASSERT_IMP(a_err_no_pend, err_q != STAT_OK, ext_q == EXT_NONE, "pending under error")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: run-length delta decoder testbench
// Streams command bytes, end-of-frame and word reads into the decoder, keeps
// a shadow frame store and decoder state, and compares each result beat
// field by field against the predicted status, word and pixel position.
// ----------------------------------------------------------------------------
module tb_top;
	import brld_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	// longest quiet stretch: clearing pass after reset plus one full-frame run
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int HOLD_CYCLES    = 400;

	typedef struct packed {
		logic [PIX_W-1:0]     pixel_position;
		logic [WORD_BITS-1:0] read_word;
		logic [1:0]           status;
	} frame_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [23:0]       s_tdata = '0;    // data_byte[7:0], read_address[20:8]
	logic [1:0]        s_tuser = '0;    // opcode[1:0]
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [55:0]       m_tdata;         // status[1:0], read_word[33:2], pixel_position[52:34]
	logic              cfg_wr_en = 1'b0;
	logic [PIX_W-1:0]  cfg_wr_data = '0;

	// shadow of the decoder
	logic [WORD_BITS-1:0] shadow_frame [STORE_WORDS];
	int                   cur_pos = 0;
	logic [1:0]           pend_kind = KIND_SKIP;
	int                   pend_len = 0;
	logic [1:0]           ext_state = EXT_NONE;
	logic [1:0]           sticky_err = STAT_OK;
	int                   frame_size = RESET_PIXELS;

	frame_result_t due_results [$];
	int mismatches = 0;
	int beats_seen = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int holds_asked = 0;
	int holds_taken = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	bitmap_run_length_delta_decoder uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// decoder prediction
	// ------------------------------------------------------------------
	function automatic void paint_run(logic [1:0] kind, int start, int len);
		int w, last_w, base, a, b;
		logic [63:0] mask;
		if (kind == KIND_SKIP || len == 0) return;
		last_w = (start + len - 1) / WORD_BITS;
		for (w = start / WORD_BITS; w <= last_w && w < STORE_WORDS; w++) begin
			base = w * WORD_BITS;
			a = (start > base) ? start - base : 0;
			b = (start + len - base < WORD_BITS) ? start + len - base : WORD_BITS;
			// MSB is the first pixel of the word
			mask = ((64'd1 << (WORD_BITS - a)) - 64'd1) & ~((64'd1 << (WORD_BITS - b)) - 64'd1);
			case (kind)
				KIND_WHITE: shadow_frame[w] = shadow_frame[w] | mask[WORD_BITS-1:0];
				KIND_BLACK: shadow_frame[w] = shadow_frame[w] & ~mask[WORD_BITS-1:0];
				default:    shadow_frame[w] = shadow_frame[w] ^ mask[WORD_BITS-1:0];
			endcase
		end
	endfunction

	function automatic void run_pixels(logic [1:0] kind, int len);
		int limit;
		limit = (frame_size > MAX_PIXELS) ? MAX_PIXELS : frame_size;
		if (cur_pos + len > limit) begin
			sticky_err = STAT_PAST_END;
			return;
		end
		paint_run(kind, cur_pos, len);
		cur_pos += len;
	endfunction

	function automatic void drop_pending();
		ext_state = EXT_NONE;
		pend_len = 0;
		pend_kind = KIND_SKIP;
	endfunction

	function automatic void close_command();
		int len;
		len = pend_len + 1;
		ext_state = EXT_NONE;
		run_pixels(pend_kind, len);
		pend_len = 0;
		pend_kind = KIND_SKIP;
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		if (sticky_err != STAT_OK) return;
		case (ext_state)
			EXT_NONE: begin
				if (b[5]) begin
					pend_kind = b[7:6];
					pend_len = int'(b[4:0]);
					ext_state = EXT_ONE;
				end else begin
					run_pixels(b[7:6], int'(b[4:0]) + 1);
				end
			end
			EXT_ONE: begin
				pend_len += (int'(b[6:0]) + 1) << 5;
				if (b[7]) ext_state = EXT_TWO;
				else close_command();
			end
			default: begin
				pend_len += (int'(b[6:0]) + 1) << 12;
				if (b[7]) begin
					// no third extension byte exists
					sticky_err = STAT_TOO_LONG;
					drop_pending();
				end else begin
					close_command();
				end
			end
		endcase
	endfunction

	function automatic frame_result_t decode_item(logic [1:0] op, logic [7:0] b,
			logic [12:0] a);
		frame_result_t r;
		r = '0;
		case (op)
			OP_BYTE: begin
				decode_byte(b);
				r.status = sticky_err;
			end
			OP_EOF: begin
				r.status = (sticky_err == STAT_OK && ext_state != EXT_NONE) ? STAT_TRUNC
					: sticky_err;
				cur_pos = 0;
				drop_pending();
				sticky_err = STAT_OK;
			end
			OP_READ: begin
				r.read_word = shadow_frame[a];
				r.status = sticky_err;
			end
			default: r.status = sticky_err;
		endcase
		r.pixel_position = cur_pos[PIX_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t beat %0d: %s expected 0x%0h, got 0x%0h",
					$time, beats_seen, name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t beat %0d: unexpected result 0x%0h", $time, beats_seen, m_tdata);
			end else begin
				want = due_results.pop_front();
				check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
				check_field("read_word", want.read_word, m_tdata[33:2]);
				check_field("pixel_position", 32'(want.pixel_position), 32'(m_tdata[52:34]));
			end
			beats_seen++;
		end
	end

	// receiver: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (holds_taken != holds_asked) begin
			holds_taken <= holds_asked;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic send_item(logic [1:0] op, logic [7:0] b, logic [12:0] a);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {3'b000, a, b};
		do @(posedge clk); while (!s_tready);
		due_results.push_back(decode_item(op, b, a));
		items_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_frame_size(logic [PIX_W-1:0] value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		frame_size = int'(value);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [12:0] pick_address();
		int words;
		words = ((frame_size > MAX_PIXELS) ? MAX_PIXELS : frame_size) / WORD_BITS;
		if ($urandom_range(3) == 0) return 13'($urandom);
		return 13'($urandom_range(words, 0));
	endfunction

	task automatic send_command(int ext_pct, int two_pct);
		logic [1:0] kind;
		logic [4:0] len5;
		logic [6:0] ext_lo, ext_hi;
		logic       two_ext, overlong;
		kind = 2'($urandom);
		len5 = 5'($urandom);
		ext_lo = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(3));
		ext_hi = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(7));
		two_ext = ($urandom_range(99) < two_pct);
		overlong = ($urandom_range(19) == 0);
		if ($urandom_range(99) >= ext_pct) begin
			send_item(OP_BYTE, {kind, 1'b0, len5}, 13'($urandom));
		end else begin
			send_item(OP_BYTE, {kind, 1'b1, len5}, 13'($urandom));
			send_item(OP_BYTE, {two_ext, ext_lo}, 13'($urandom));
			if (two_ext) send_item(OP_BYTE, {overlong, ext_hi}, 13'($urandom));
		end
	endtask

	// mostly whole frames of random commands, some noise and cut-off commands
	task automatic random_traffic(int n_items, int ext_pct, int two_pct);
		int stop_at, roll;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			roll = $urandom_range(99);
			if (roll < 80) begin
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(4) == 0) send_item(OP_READ, 8'($urandom), pick_address());
					send_command(ext_pct, two_pct);
				end
				send_item(OP_EOF, 8'($urandom), 13'($urandom));
			end else if (roll < 90) begin
				send_item(2'($urandom), 8'($urandom), 13'($urandom));
			end else begin
				send_item(OP_BYTE, {2'($urandom), 1'b1, 5'($urandom)}, 13'($urandom));
				if ($urandom_range(1) == 1)
					send_item(OP_BYTE, {1'b1, 7'($urandom)}, 13'($urandom));
				send_item(OP_EOF, 8'($urandom), 13'($urandom));
			end
		end
	endtask

	task automatic run_phase(int snd_pct, int rcv_pct, logic [PIX_W-1:0] fsize, int n_items,
			int ext_pct, int two_pct);
		write_frame_size(fsize);
		send_idle_pct = snd_pct;
		recv_stall_pct = rcv_pct;
		random_traffic(n_items, ext_pct, two_pct);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed_runs();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_item(OP_READ, 8'h00, 13'h0000);
		send_item(OP_READ, 8'hFF, 13'h1FFF);
		send_item(OP_BYTE, {KIND_WHITE, 1'b0, 5'd0}, 13'h0000);
		send_item(OP_BYTE, {KIND_BLACK, 1'b0, 5'd31}, 13'h0000);
		send_item(OP_BYTE, {KIND_INVERT, 1'b0, 5'd4}, 13'h0000);
		send_item(OP_BYTE, {KIND_SKIP, 1'b0, 5'd6}, 13'h0000);
		// one extension byte
		send_item(OP_BYTE, {KIND_WHITE, 1'b1, 5'd31}, 13'h0000);
		send_item(OP_BYTE, {1'b0, 7'd5}, 13'h0000);
		// two extension bytes
		send_item(OP_BYTE, {KIND_INVERT, 1'b1, 5'd3}, 13'h0000);
		send_item(OP_BYTE, {1'b1, 7'd1}, 13'h0000);
		send_item(OP_BYTE, {1'b0, 7'd0}, 13'h0000);
		send_item(OP_READ, 8'h00, 13'h0000);
		send_item(OP_READ, 8'h00, 13'h0001);
		send_item(OP_EOF, 8'h00, 13'h0000);
	endtask

	task automatic test_error_cases();
		// invert the whole frame in one run: 31 + 127*32 + 63*4096 + 1 pixels
		send_item(OP_BYTE, {KIND_INVERT, 1'b1, 5'd31}, 13'h0000);
		send_item(OP_BYTE, {1'b1, 7'd126}, 13'h0000);
		send_item(OP_BYTE, {1'b0, 7'd62}, 13'h0000);
		send_item(OP_READ, 8'h00, 13'h1FFF);
		// run past the frame end, then a byte that the sticky error swallows
		send_item(OP_BYTE, {KIND_SKIP, 1'b0, 5'd0}, 13'h0000);
		send_item(OP_BYTE, {KIND_WHITE, 1'b0, 5'd0}, 13'h0000);
		send_item(OP_EOF, 8'h00, 13'h0000);
		// continuation bit on the second extension byte
		send_item(OP_BYTE, {KIND_BLACK, 1'b1, 5'd3}, 13'h0000);
		send_item(OP_BYTE, {1'b1, 7'd0}, 13'h0000);
		send_item(OP_BYTE, {1'b1, 7'd0}, 13'h0000);
		send_item(OP_EOF, 8'h00, 13'h0000);
		// frame ends with a command still open
		send_item(OP_BYTE, {KIND_WHITE, 1'b1, 5'd0}, 13'h0000);
		send_item(OP_EOF, 8'h00, 13'h0000);
		send_item(OP_UNUSED, 8'hFF, 13'h1FFF);
	endtask

	task automatic test_frame_size_extremes();
		// empty frame: every run overflows
		write_frame_size('0);
		send_item(OP_BYTE, {KIND_SKIP, 1'b0, 5'd0}, 13'h0000);
		send_item(OP_EOF, 8'h00, 13'h0000);
		write_frame_size(PIX_W'(1));
		send_item(OP_BYTE, {KIND_WHITE, 1'b0, 5'd0}, 13'h0000);
		send_item(OP_READ, 8'h00, 13'h0000);
		send_item(OP_BYTE, {KIND_SKIP, 1'b0, 5'd0}, 13'h0000);
		send_item(OP_EOF, 8'h00, 13'h0000);
		// above the store size the frame is clamped
		write_frame_size('1);
		send_item(OP_BYTE, {KIND_SKIP, 1'b1, 5'd31}, 13'h0000);
		send_item(OP_BYTE, {1'b1, 7'd126}, 13'h0000);
		send_item(OP_BYTE, {1'b0, 7'd62}, 13'h0000);
		send_item(OP_BYTE, {KIND_SKIP, 1'b0, 5'd0}, 13'h0000);
		send_item(OP_EOF, 8'h00, 13'h0000);
	endtask

	task automatic test_random_mix();
		run_phase(0, 0, PIX_W'($urandom_range(64, 2048)), 125, 30, 10);
		run_phase(0, 0, PIX_W'(RESET_PIXELS), 125, 20, 5);
		run_phase(83, 0, PIX_W'($urandom_range(64, 2048)), 125, 30, 10);
		run_phase(83, 0, PIX_W'(1), 60, 30, 10);
		run_phase(0, 83, PIX_W'($urandom_range(64, 2048)), 125, 30, 10);
		run_phase(0, 83, '1, 125, 20, 5);
		run_phase(37, 37, PIX_W'($urandom_range(64, 2048)), 125, 30, 10);
		run_phase(37, 37, PIX_W'($urandom_range(1, 64)), 80, 30, 10);
	endtask

	// output held off for a long stretch while input keeps coming
	task automatic test_backpressure();
		write_frame_size(PIX_W'($urandom_range(256, 1024)));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holds_asked++;
		random_traffic(40, 20, 5);
		wait_drained();
	endtask

	initial begin
		foreach (shadow_frame[i]) shadow_frame[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_runs();
		test_error_cases();
		test_frame_size_extremes();
		test_random_mix();
		test_backpressure();
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/brld_pkg.sv
hdl/bitmap_run_length_delta_decoder.sv
verif/tb_top.sv
